### hw/rtl/fwrld_pkg.sv
// Shared types, constants and a helper function of the firmware image run-length decoder.
package fwrld_pkg;

    // Field widths.
    localparam int ADDR_W      = 32;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int ACTION_W    = 2;
    localparam int COUNT_W     = 31;
    localparam int RUN_LEN_W   = 9;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Register reset values.
    localparam logic [BYTE_W-1:0] LITERAL_OP_BASE_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] ZERO_OP_BASE_RESET    = 8'd64;
    localparam logic [BYTE_W-1:0] NOP_OP_BASE_RESET     = 8'd128;
    localparam logic [WORD_W-1:0] NOP_WORD_RESET        = 32'h7040_0101;

    // Input action codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_BEGIN = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_END   = 2'd2
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_BASE     = 3'd0,
        REG_IMAGE_START     = 3'd1,
        REG_WINDOW_END      = 3'd2,
        REG_LITERAL_OP_BASE = 3'd3,
        REG_ZERO_OP_BASE    = 3'd4,
        REG_NOP_OP_BASE     = 3'd5,
        REG_NOP_WORD        = 3'd6
    } reg_index_t;

    // Configuration register set.
    typedef struct packed {
        logic [ADDR_W-1:0] window_base;
        logic [ADDR_W-1:0] image_start;
        logic [ADDR_W-1:0] window_end;
        logic [BYTE_W-1:0] literal_op_base;
        logic [BYTE_W-1:0] zero_op_base;
        logic [BYTE_W-1:0] nop_op_base;
        logic [WORD_W-1:0] nop_word;
    } cfg_t;

    // Kinds of command handed from front to back.
    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_END   = 2'd2
    } cmd_kind_t;

    // One classified command: the back part resolves addresses and counts.
    typedef struct packed {
        cmd_kind_t              kind;
        logic [WORD_W-1:0]      value;
        logic [RUN_LEN_W-1:0]   run_len;
        logic                   status;
    } cmd_t;

    // Number of 32-bit words needed to cover [from_addr, to_addr), zero if empty.
    function automatic logic [COUNT_W-1:0] words_to(input logic [ADDR_W-1:0] from_addr,
                                                    input logic [ADDR_W-1:0] to_addr);
        logic [ADDR_W:0] span;
        begin
            span = {1'b0, to_addr - from_addr} + 33'd3;
            if (from_addr >= to_addr)
                words_to = '0;
            else
                words_to = span[ADDR_W:2];
        end
    endfunction

endpackage

### hw/rtl/fwrld_if.sv
// Channel interfaces of the decoder: input items, result items and configuration writes.
interface fwrld_item_if import fwrld_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   byte_value;

    modport source (output valid, action, byte_value, input ready);
    modport sink (input valid, action, byte_value, output ready);
endinterface

interface fwrld_result_if import fwrld_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  word_address;
    logic [WORD_W-1:0]  word_value;
    logic [COUNT_W-1:0] repeat_count;
    logic               last;
    logic               status;

    modport source (output valid, word_address, word_value, repeat_count, last, status,
                    input ready);
    modport sink (input valid, word_address, word_value, repeat_count, last, status,
                  output ready);
endinterface

interface fwrld_cfg_if import fwrld_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/fwrld_front.sv
// Front part: accepts input transactions, tracks stream state and classifies opcodes.
module fwrld_front import fwrld_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    fwrld_item_if.sink   item,
    input  cfg_t         cfg_regs,
    input  logic         queue_full,
    output logic         push,
    output cmd_t         push_cmd
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_OPCODE,
        PH_LITERAL
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [1:0]          lane_reg, lane_next;
    logic [23:0]         partial_reg, partial_next;
    logic [BYTE_W-1:0]   left_reg, left_next;
    logic [ADDR_W-1:0]   bytes_seen_reg, bytes_seen_next;
    logic                range_err_reg, range_err_next;

    logic                accept;
    logic [ADDR_W-1:0]   bytes_seen_sat;
    logic                overrun;
    logic                err_after_byte;
    logic [BYTE_W-1:0]   b;
    logic [BYTE_W-1:0]   run_base;

    // A transaction is taken whenever the queue has room.
    assign item.ready = !queue_full;
    assign accept     = item.valid && item.ready;
    assign b          = item.byte_value;

    // Saturating byte count and the mid-stream window check.
    assign bytes_seen_sat = (bytes_seen_reg == '1) ? bytes_seen_reg : bytes_seen_reg + 32'd1;
    assign overrun = ({1'b0, cfg_regs.image_start} + {1'b0, bytes_seen_sat})
                     > {1'b0, cfg_regs.window_end};
    assign err_after_byte = range_err_reg || overrun;
    assign run_base = (b < cfg_regs.nop_op_base) ? cfg_regs.zero_op_base
                                                 : cfg_regs.nop_op_base;

    // Next-state and command generation.
    always_comb
    begin
        phase_next       = phase_reg;
        lane_next        = lane_reg;
        partial_next     = partial_reg;
        left_next        = left_reg;
        bytes_seen_next  = bytes_seen_reg;
        range_err_next   = range_err_reg;
        push             = 1'b0;
        push_cmd.kind    = CMD_RUN;
        push_cmd.value   = '0;
        push_cmd.run_len = RUN_LEN_W'(1);
        push_cmd.status  = range_err_reg;

        if (accept)
        begin
            unique case (item.action)
                ACT_BEGIN:
                begin
                    phase_next      = PH_OPCODE;
                    lane_next       = '0;
                    partial_next    = '0;
                    left_next       = '0;
                    bytes_seen_next = '0;
                    range_err_next  = (cfg_regs.window_base > cfg_regs.image_start)
                                      || (cfg_regs.image_start > cfg_regs.window_end);
                    push            = 1'b1;
                    push_cmd.kind   = CMD_BEGIN;
                    push_cmd.status = range_err_next;
                end
                ACT_END:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        phase_next    = PH_IDLE;
                        lane_next     = '0;
                        partial_next  = '0;
                        left_next     = '0;
                        push          = 1'b1;
                        push_cmd.kind = CMD_END;
                    end
                end
                ACT_BYTE:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        bytes_seen_next = bytes_seen_sat;
                        range_err_next  = err_after_byte;
                        push_cmd.status = err_after_byte;
                        if (phase_reg == PH_LITERAL)
                        begin
                            // Assemble literal words most significant byte first.
                            if (lane_reg != 2'd3)
                            begin
                                partial_next = {partial_reg[15:0], b};
                                lane_next    = lane_reg + 2'd1;
                            end
                            else
                            begin
                                push           = 1'b1;
                                push_cmd.value = {partial_reg, b};
                                lane_next      = '0;
                                partial_next   = '0;
                                if (left_reg == '0)
                                    phase_next = PH_OPCODE;
                                else
                                    left_next = left_reg - 8'd1;
                            end
                        end
                        else if (b < cfg_regs.zero_op_base)
                        begin
                            phase_next   = PH_LITERAL;
                            lane_next    = '0;
                            partial_next = '0;
                            left_next    = b - cfg_regs.literal_op_base;
                        end
                        else
                        begin
                            // Zero or no-op run of one to 256 words.
                            push             = 1'b1;
                            push_cmd.value   = (b < cfg_regs.nop_op_base) ? '0
                                                                          : cfg_regs.nop_word;
                            push_cmd.run_len = {1'b0, b - run_base} + 9'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Stream state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            lane_reg       <= '0;
            partial_reg    <= '0;
            left_reg       <= '0;
            bytes_seen_reg <= '0;
            range_err_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            lane_reg       <= lane_next;
            partial_reg    <= partial_next;
            left_reg       <= left_next;
            bytes_seen_reg <= bytes_seen_next;
            range_err_reg  <= range_err_next;
        end
    end

endmodule

### hw/rtl/fwrld_queue.sv
// Command queue that decouples the front part from the back part.
module fwrld_queue import fwrld_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head  = entries[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

### hw/rtl/fwrld_back.sv
// Back part: resolves run addresses and counts and drives the result register.
module fwrld_back import fwrld_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg_regs,
    input  logic           queue_empty,
    input  cmd_t           head,
    output logic           pop,
    fwrld_result_if.source result
);

    logic               out_valid_reg;
    logic [ADDR_W-1:0]  next_addr_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [WORD_W-1:0]  value_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               last_reg;
    logic               status_reg;

    logic [ADDR_W-1:0]  from_addr;
    logic [ADDR_W-1:0]  to_addr;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  next_addr;

    // Take the next command when the result register is free or being emptied.
    assign pop = !queue_empty && (!out_valid_reg || result.ready);

    // Begin runs start at the window base, all others at the running address.
    assign from_addr = (head.kind == CMD_BEGIN) ? cfg_regs.window_base : next_addr_reg;
    assign to_addr   = (head.kind == CMD_BEGIN) ? cfg_regs.image_start : cfg_regs.window_end;
    assign count     = (head.kind == CMD_RUN)
                       ? {{(COUNT_W - RUN_LEN_W){1'b0}}, head.run_len}
                       : words_to(from_addr, to_addr);
    assign next_addr = from_addr + {count[ADDR_W-3:0], 2'b00};

    // Valid flag and running address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            next_addr_reg <= '0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
            next_addr_reg <= next_addr;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg   <= from_addr;
            value_reg  <= head.value;
            count_reg  <= count;
            last_reg   <= (head.kind == CMD_END);
            status_reg <= head.status;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.word_address = addr_reg;
    assign result.word_value   = value_reg;
    assign result.repeat_count = count_reg;
    assign result.last         = last_reg;
    assign result.status       = status_reg;

endmodule

### hw/rtl/firmware_image_run_length_decoder_top.sv
// Top level of the firmware image run-length decoder: registers, front, queue and back.
// The decoder takes one input transaction per clock cycle while the queue has room and
// delivers at most one result transaction per cycle. For an item that causes a result,
// the front part classifies the item and updates the stream state in the accept cycle,
// the command is written into the queue at the accepting edge, and once the result
// register is free or being emptied, the back part takes the command from the queue and
// resolves the run address and word count into the result register. A queue of
// QueueDepth commands lets either side stall on its own; input is refused only while the
// queue is full. Each run, including the begin and end padding, is one result with a
// repeat count, so the rate does not depend on run length.
// Configuration writes are taken in every cycle and belong to idle periods.
module firmware_image_run_length_decoder_top import fwrld_pkg::*; #(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    fwrld_item_if.sink     item,
    fwrld_result_if.source result,
    fwrld_cfg_if.sink      cfg
);

    cfg_t cfg_reg;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head;
    logic queue_full;
    logic queue_empty;

    // Configuration register file.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_base     <= '0;
            cfg_reg.image_start     <= '0;
            cfg_reg.window_end      <= '0;
            cfg_reg.literal_op_base <= LITERAL_OP_BASE_RESET;
            cfg_reg.zero_op_base    <= ZERO_OP_BASE_RESET;
            cfg_reg.nop_op_base     <= NOP_OP_BASE_RESET;
            cfg_reg.nop_word        <= NOP_WORD_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_WINDOW_BASE:     cfg_reg.window_base     <= cfg.data;
                REG_IMAGE_START:     cfg_reg.image_start     <= cfg.data;
                REG_WINDOW_END:      cfg_reg.window_end      <= cfg.data;
                REG_LITERAL_OP_BASE: cfg_reg.literal_op_base <= cfg.data[BYTE_W-1:0];
                REG_ZERO_OP_BASE:    cfg_reg.zero_op_base    <= cfg.data[BYTE_W-1:0];
                REG_NOP_OP_BASE:     cfg_reg.nop_op_base     <= cfg.data[BYTE_W-1:0];
                REG_NOP_WORD:        cfg_reg.nop_word        <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Front part: stream state and opcode classification.
    fwrld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg_regs   (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue between the two parts.
    fwrld_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // Back part: addresses, counts and the result register.
    fwrld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_regs    (cfg_reg),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .result      (result)
    );

endmodule

### hw/rtl/fwrld_checker.sv
// Port-level assertions of the decoder and the bind that attaches them to the top level.
module fwrld_checker import fwrld_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input logic [WORD_W-1:0]  word_value,
    input logic [COUNT_W-1:0] repeat_count,
    input logic               last
);

    // A result transaction that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid)
    else $error("result valid dropped before the transaction completed");

    // End padding is always a run of zero words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> (word_value == '0))
    else $error("end result carries a nonzero word value");

    // Apart from end padding, only begin padding can be empty, and it is zero-valued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last && (repeat_count == '0)) |-> (word_value == '0))
    else $error("empty run with a nonzero word value");

    // A run never covers more than the whole address space.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (repeat_count <= 31'h4000_0000))
    else $error("repeat count beyond the address space");

endmodule

bind firmware_image_run_length_decoder_top fwrld_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .word_value   (result.word_value),
    .repeat_count (result.repeat_count),
    .last         (result.last)
);
